// File: design/extendible_hash_table_assert.svh
// ----------------------------------------------------------------------------
// extendible_hash_table_assert.svh
// assertion macros used by the checker file
// ----------------------------------------------------------------------------
`ifndef EXTENDIBLE_HASH_TABLE_ASSERT_SVH
`define EXTENDIBLE_HASH_TABLE_ASSERT_SVH

// same-cycle implication, clocked on clk, quiet during reset
`define EHT_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk, quiet during reset
`define EHT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/eht_pkg.sv
// ----------------------------------------------------------------------------
// eht_pkg
// constants, codes and controller/datapath types of the extendible hash table
// ----------------------------------------------------------------------------
package eht_pkg;

  // table geometry
  localparam int MAX_DEPTH    = 8;
  localparam int BUCKET_SLOTS = 8;
  localparam int KEY_BITS     = 32;

  localparam int DIR_SIZE  = 1 << MAX_DEPTH;
  localparam int DIR_W     = MAX_DEPTH;
  localparam int SLOT_W    = (BUCKET_SLOTS > 1) ? $clog2(BUCKET_SLOTS) : 1;
  localparam int KEY_DEPTH = DIR_SIZE << SLOT_W;
  localparam int KADDR_W   = DIR_W + SLOT_W;
  localparam int SWP_W     = ((DIR_W > SLOT_W) ? DIR_W : SLOT_W) + 1;
  localparam int CNT_W     = $clog2(BUCKET_SLOTS + 1);

  // field widths
  localparam int DEPTH_W   = 4;
  localparam int CFG_W     = 4;
  localparam int OP_W      = 2;
  localparam int STAT_W    = 3;
  localparam int BKT_OUT_W = 8;
  localparam int PADDR_W   = 3;
  localparam int PDATA_W   = 32;

  // register reset values
  localparam int INIT_DEPTH_RST = 1;
  localparam int BKT_CAP_RST    = (4 > BUCKET_SLOTS) ? BUCKET_SLOTS : 4;

  // register indexes
  localparam logic REG_INIT_DEPTH = 1'b0;
  localparam logic REG_BKT_CAP    = 1'b1;

  // operation codes
  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_SEARCH = 2'd1;
  localparam logic [OP_W-1:0] OP_DELETE = 2'd2;

  typedef enum logic [STAT_W-1:0] {
    ST_INSERTED = 3'd0,
    ST_FOUND    = 3'd1,
    ST_NOTFOUND = 3'd2,
    ST_DELETED  = 3'd3,
    ST_PRESENT  = 3'd4,
    ST_FULL     = 3'd5
  } status_t;

  // datapath micro-operations
  typedef enum logic [4:0] {
    A_IDLE, A_NOP, A_CLEAR, A_DIR, A_BKT, A_ROW, A_SCAN, A_DEL, A_PUT,
    A_DBL, A_GDINC, A_SPL0, A_SPL1, A_SDIR, A_MOVE, A_WBB, A_WBN, A_OUT
  } act_t;

  typedef struct packed {
    act_t    act;
    status_t res;
  } eht_cmd_t;

  typedef struct packed {
    logic            in_valid;
    logic            rebuild;
    logic            sweep_done;
    logic            hit;
    logic [OP_W-1:0] op;
    logic            room;
    logic            ld_ge;
    logic            gd_max;
    logic            alloc_full;
    logic            out_free;
  } eht_stat_t;

endpackage

// File: design/eht_in_if.sv
// ----------------------------------------------------------------------------
// eht_in_if
// request channel: operation and key
// ----------------------------------------------------------------------------
interface eht_in_if import eht_pkg::*;;
  logic                valid;
  logic                ready;
  logic [OP_W-1:0]     op;
  logic [KEY_BITS-1:0] key;

  modport source (output valid, output op, output key, input ready);
  modport sink   (input valid, input op, input key, output ready);
endinterface

// File: design/eht_out_if.sv
// ----------------------------------------------------------------------------
// eht_out_if
// result channel: status, bucket and global depth
// ----------------------------------------------------------------------------
interface eht_out_if import eht_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic [STAT_W-1:0]    status;
  logic [BKT_OUT_W-1:0] bucket_used;
  logic [DEPTH_W-1:0]   depth_now;

  modport source (output valid, output status, output bucket_used, output depth_now,
                  input ready);
  modport sink   (input valid, input status, input bucket_used, input depth_now,
                  output ready);
endinterface

// File: design/eht_ram.sv
// ----------------------------------------------------------------------------
// eht_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module eht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

// File: design/eht_ctrl.sv
// ----------------------------------------------------------------------------
// eht_ctrl
// sequencer: lookup, bucket scan, insert with split and directory doubling
// ----------------------------------------------------------------------------
module eht_ctrl import eht_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  eht_stat_t stat,
  output eht_cmd_t  cmd,
  output logic      in_ready
);

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_DIR, S_BKT, S_ROW, S_SCAN, S_DECIDE, S_INS, S_DBL,
    S_GDINC, S_SPL0, S_SPL1, S_SDIR, S_MOVE, S_WBB, S_WBN, S_OUT
  } state_t;

  state_t  state_r, state_nxt;
  logic    retry_r, retry_nxt;
  status_t res_r, res_nxt;

  // next state and micro-operation
  always_comb begin
    state_nxt = state_r;
    retry_nxt = retry_r;
    res_nxt   = res_r;
    cmd.act   = A_NOP;
    cmd.res   = res_r;
    in_ready  = 1'b0;
    case (state_r)
      S_CLEAR: begin
        cmd.act = A_CLEAR;
        if (stat.sweep_done) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        cmd.act  = A_IDLE;
        in_ready = !stat.rebuild;
        if (stat.rebuild) begin
          state_nxt = S_CLEAR;
        end else if (stat.in_valid) begin
          state_nxt = S_DIR;
          retry_nxt = 1'b0;
        end
      end
      S_DIR: begin
        cmd.act   = A_DIR;
        state_nxt = S_BKT;
      end
      S_BKT: begin
        cmd.act   = A_BKT;
        state_nxt = S_ROW;
      end
      S_ROW: begin
        cmd.act   = A_ROW;
        state_nxt = retry_r ? S_INS : S_SCAN;
      end
      S_SCAN: begin
        cmd.act = A_SCAN;
        if (stat.sweep_done) state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        state_nxt = S_OUT;
        case (stat.op)
          OP_INSERT: begin
            if (stat.hit) begin
              res_nxt = ST_PRESENT;
            end else begin
              retry_nxt = 1'b1;
              state_nxt = S_INS;
            end
          end
          OP_DELETE: begin
            if (stat.hit) begin
              cmd.act = A_DEL;
              res_nxt = ST_DELETED;
            end else begin
              res_nxt = ST_NOTFOUND;
            end
          end
          default: begin
            res_nxt = stat.hit ? ST_FOUND : ST_NOTFOUND;
          end
        endcase
      end
      // room left, or split with doubling first where needed, else report full
      S_INS: begin
        if (stat.room) begin
          cmd.act   = A_PUT;
          res_nxt   = ST_INSERTED;
          state_nxt = S_OUT;
        end else if (stat.ld_ge) begin
          if (stat.gd_max) begin
            res_nxt   = ST_FULL;
            state_nxt = S_OUT;
          end else begin
            state_nxt = S_DBL;
          end
        end else if (stat.alloc_full) begin
          res_nxt   = ST_FULL;
          state_nxt = S_OUT;
        end else begin
          state_nxt = S_SPL0;
        end
      end
      S_DBL: begin
        cmd.act = A_DBL;
        if (stat.sweep_done) state_nxt = S_GDINC;
      end
      S_GDINC: begin
        cmd.act = A_GDINC;
        if (stat.alloc_full) begin
          res_nxt   = ST_FULL;
          state_nxt = S_OUT;
        end else begin
          state_nxt = S_SPL0;
        end
      end
      S_SPL0: begin
        cmd.act   = A_SPL0;
        state_nxt = S_SPL1;
      end
      S_SPL1: begin
        cmd.act   = A_SPL1;
        state_nxt = S_SDIR;
      end
      S_SDIR: begin
        cmd.act = A_SDIR;
        if (stat.sweep_done) state_nxt = S_MOVE;
      end
      S_MOVE: begin
        cmd.act = A_MOVE;
        if (stat.sweep_done) state_nxt = S_WBB;
      end
      S_WBB: begin
        cmd.act   = A_WBB;
        state_nxt = S_WBN;
      end
      S_WBN: begin
        cmd.act   = A_WBN;
        state_nxt = S_DIR;
      end
      S_OUT: begin
        cmd.act = A_OUT;
        if (stat.out_free) state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  // state and registered flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      retry_r <= 1'b0;
      res_r   <= ST_INSERTED;
    end else begin
      state_r <= state_nxt;
      retry_r <= retry_nxt;
      res_r   <= res_nxt;
    end
  end

endmodule

// File: design/eht_datapath.sv
// ----------------------------------------------------------------------------
// eht_datapath
// directory, local depth, slot valid and key memories, config and result regs
// ----------------------------------------------------------------------------
module eht_datapath import eht_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  eht_cmd_t             cmd,
  output eht_stat_t            stat,
  input  logic                 in_valid,
  input  logic                 in_accept,
  input  logic [OP_W-1:0]      in_op,
  input  logic [KEY_BITS-1:0]  in_key,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [PADDR_W-1:0]   paddr,
  input  logic [PDATA_W-1:0]   pwdata,
  output logic [PDATA_W-1:0]   prdata,
  input  logic                 out_ready,
  output logic                 out_valid,
  output logic [STAT_W-1:0]    out_status,
  output logic [BKT_OUT_W-1:0] out_bucket_used,
  output logic [DEPTH_W-1:0]   out_depth_now
);

  function automatic logic [CFG_W-1:0] sat_cfg(input logic [CFG_W-1:0] v,
                                               input logic [CFG_W-1:0] hi);
    logic [CFG_W-1:0] r;
    r = (v == '0) ? CFG_W'(1) : v;
    if (r > hi) r = hi;
    return r;
  endfunction

  logic [CFG_W-1:0]        init_r, cap_r;
  logic [DEPTH_W-1:0]      gd_r, ld_r;
  logic [DIR_W:0]          alloc_r;
  logic [SWP_W-1:0]        cnt_r, cnt_nxt, cnt_m1;
  logic [OP_W-1:0]         op_r;
  logic [KEY_BITS-1:0]     key_r;
  logic [DIR_W-1:0]        b_r, nb_r;
  logic [BUCKET_SLOTS-1:0] vb_r, vn_r;
  logic                    hit_r;
  logic [SLOT_W-1:0]       hslot_r;
  logic [SLOT_W:0]         mv_r;
  logic                    out_valid_r;
  status_t                 out_status_r;
  logic [DIR_W-1:0]        out_bkt_r;
  logic [DEPTH_W-1:0]      out_depth_r;

  logic                    cfg_wr, reg_idx, out_free, sweep, done;
  logic [CFG_W-1:0]        depth_wv;
  logic [DIR_W:0]          gd_n, init_n;
  logic [DIR_W-1:0]        dir_idx, ld_bit;
  logic [DEPTH_W-1:0]      ld_m1;
  logic [SLOT_W-1:0]       ps, free_s;
  logic [CNT_W-1:0]        used;
  logic                    scan_hit, sdir_hit, mv_hit;

  logic                    dir_we, ld_we, vld_we, key_we;
  logic [DIR_W-1:0]        dir_waddr, dir_wdata, dir_raddr, dir_rdata;
  logic [DIR_W-1:0]        ld_waddr, vld_waddr, bkt_raddr;
  logic [DEPTH_W-1:0]      ld_wdata, ld_rdata;
  logic [BUCKET_SLOTS-1:0] vld_wdata, vld_rdata;
  logic [KADDR_W-1:0]      key_waddr, key_raddr;
  logic [KEY_BITS-1:0]     key_wdata, key_rdata;

  // config port decode
  assign cfg_wr   = psel && penable && pwrite;
  assign reg_idx  = paddr[PADDR_W-1];
  assign depth_wv = sat_cfg(pwdata[CFG_W-1:0], CFG_W'(MAX_DEPTH));
  assign prdata   = (reg_idx == REG_INIT_DEPTH) ? PDATA_W'(init_r) : PDATA_W'(cap_r);

  // directory geometry
  assign gd_n    = (DIR_W + 1)'(1) << gd_r;
  assign init_n  = (DIR_W + 1)'(1) << init_r;
  assign dir_idx = key_r[DIR_W-1:0] & DIR_W'(gd_n - 1'b1);
  assign ld_m1   = ld_r - DEPTH_W'(1);
  assign ld_bit  = DIR_W'(1) << ld_m1;
  assign cnt_m1  = cnt_r - SWP_W'(1);
  assign ps      = cnt_m1[SLOT_W-1:0];

  // slot occupancy and first free slot
  always_comb begin
    used   = '0;
    free_s = '0;
    for (int s = BUCKET_SLOTS - 1; s >= 0; s--) begin
      used = used + CNT_W'(vb_r[s]);
      if (!vb_r[s]) free_s = SLOT_W'(s);
    end
  end

  // sweep counter end points
  always_comb begin
    sweep = 1'b1;
    done  = 1'b0;
    case (cmd.act)
      A_CLEAR:        done = (cnt_r == SWP_W'(DIR_SIZE - 1));
      A_DBL, A_SDIR:  done = (cnt_r == SWP_W'(gd_n));
      A_SCAN, A_MOVE: done = (cnt_r == SWP_W'(BUCKET_SLOTS));
      default:        sweep = 1'b0;
    endcase
    cnt_nxt = (sweep && !done) ? cnt_r + SWP_W'(1) : '0;
  end

  // compares on the data read for the previous count
  assign scan_hit = (cmd.act == A_SCAN) && (cnt_r != '0) && vb_r[ps] && (key_rdata == key_r);
  assign sdir_hit = (cmd.act == A_SDIR) && (cnt_r != '0) && (dir_rdata == b_r) &&
                    (|(cnt_m1[DIR_W-1:0] & ld_bit));
  assign mv_hit   = (cmd.act == A_MOVE) && (cnt_r != '0) && vb_r[ps] &&
                    (|(key_rdata[DIR_W-1:0] & ld_bit));

  // memory port steering
  always_comb begin
    dir_we    = 1'b0;
    dir_waddr = cnt_r[DIR_W-1:0];
    dir_wdata = cnt_r[DIR_W-1:0] & DIR_W'(init_n - 1'b1);
    dir_raddr = dir_idx;
    ld_we     = 1'b0;
    ld_waddr  = cnt_r[DIR_W-1:0];
    ld_wdata  = DEPTH_W'(init_r);
    vld_we    = 1'b0;
    vld_waddr = b_r;
    vld_wdata = vb_r;
    key_we    = 1'b0;
    key_waddr = {b_r, free_s};
    key_wdata = key_r;
    key_raddr = {b_r, cnt_r[SLOT_W-1:0]};
    bkt_raddr = dir_rdata;
    case (cmd.act)
      A_CLEAR: begin
        dir_we    = 1'b1;
        ld_we     = 1'b1;
        vld_we    = 1'b1;
        vld_waddr = cnt_r[DIR_W-1:0];
        vld_wdata = '0;
      end
      A_DEL: begin
        vld_we    = 1'b1;
        vld_wdata = vb_r & ~(BUCKET_SLOTS'(1) << hslot_r);
      end
      A_PUT: begin
        vld_we    = 1'b1;
        vld_wdata = vb_r | (BUCKET_SLOTS'(1) << free_s);
        key_we    = 1'b1;
      end
      A_DBL: begin
        dir_raddr = cnt_r[DIR_W-1:0];
        dir_we    = (cnt_r != '0);
        dir_waddr = DIR_W'(SWP_W'(gd_n) + cnt_m1);
        dir_wdata = dir_rdata;
      end
      A_SPL0: begin
        ld_we    = 1'b1;
        ld_waddr = b_r;
        ld_wdata = ld_r + DEPTH_W'(1);
      end
      A_SPL1: begin
        ld_we    = 1'b1;
        ld_waddr = nb_r;
        ld_wdata = ld_r;
      end
      A_SDIR: begin
        dir_raddr = cnt_r[DIR_W-1:0];
        dir_we    = sdir_hit;
        dir_waddr = cnt_m1[DIR_W-1:0];
        dir_wdata = nb_r;
      end
      A_MOVE: begin
        key_we    = mv_hit;
        key_waddr = {nb_r, mv_r[SLOT_W-1:0]};
        key_wdata = key_rdata;
      end
      A_WBB: begin
        vld_we = 1'b1;
      end
      A_WBN: begin
        vld_we    = 1'b1;
        vld_waddr = nb_r;
        vld_wdata = vn_r;
      end
      default: begin
      end
    endcase
  end

  eht_ram #(.WIDTH(DIR_W), .DEPTH(DIR_SIZE)) u_dir_ram (
    .clk(clk), .we(dir_we), .waddr(dir_waddr), .wdata(dir_wdata),
    .raddr(dir_raddr), .rdata(dir_rdata)
  );

  eht_ram #(.WIDTH(DEPTH_W), .DEPTH(DIR_SIZE)) u_ld_ram (
    .clk(clk), .we(ld_we), .waddr(ld_waddr), .wdata(ld_wdata),
    .raddr(bkt_raddr), .rdata(ld_rdata)
  );

  eht_ram #(.WIDTH(BUCKET_SLOTS), .DEPTH(DIR_SIZE)) u_vld_ram (
    .clk(clk), .we(vld_we), .waddr(vld_waddr), .wdata(vld_wdata),
    .raddr(bkt_raddr), .rdata(vld_rdata)
  );

  eht_ram #(.WIDTH(KEY_BITS), .DEPTH(KEY_DEPTH)) u_key_ram (
    .clk(clk), .we(key_we), .waddr(key_waddr), .wdata(key_wdata),
    .raddr(key_raddr), .rdata(key_rdata)
  );

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init_r      <= CFG_W'(INIT_DEPTH_RST);
      cap_r       <= CFG_W'(BKT_CAP_RST);
      gd_r        <= DEPTH_W'(INIT_DEPTH_RST);
      alloc_r     <= (DIR_W + 1)'(1) << INIT_DEPTH_RST;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (cfg_wr && reg_idx == REG_INIT_DEPTH) begin
        init_r  <= depth_wv;
        gd_r    <= DEPTH_W'(depth_wv);
        alloc_r <= (DIR_W + 1)'(1) << depth_wv;
      end
      if (cfg_wr && reg_idx == REG_BKT_CAP) begin
        cap_r <= sat_cfg(pwdata[CFG_W-1:0], CFG_W'(BUCKET_SLOTS));
      end
      if (cmd.act == A_GDINC) gd_r <= gd_r + DEPTH_W'(1);
      if (cmd.act == A_SPL0) alloc_r <= alloc_r + 1'b1;
      if (cmd.act == A_OUT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // item and bucket working registers
  always_ff @(posedge clk) begin
    if (cmd.act == A_IDLE && in_accept) begin
      op_r  <= in_op;
      key_r <= in_key;
    end
    if (cmd.act == A_BKT) b_r <= dir_rdata;
    if (cmd.act == A_ROW) begin
      vb_r  <= vld_rdata;
      ld_r  <= ld_rdata;
      hit_r <= 1'b0;
    end
    if (scan_hit) begin
      hit_r   <= 1'b1;
      hslot_r <= ps;
    end
    if (cmd.act == A_SPL0) begin
      nb_r <= alloc_r[DIR_W-1:0];
      ld_r <= ld_r + DEPTH_W'(1);
      vn_r <= '0;
      mv_r <= '0;
    end
    if (mv_hit) begin
      vn_r[mv_r[SLOT_W-1:0]] <= 1'b1;
      vb_r[ps]               <= 1'b0;
      mv_r                   <= mv_r + 1'b1;
    end
    if (cmd.act == A_OUT && out_free) begin
      out_status_r <= cmd.res;
      out_bkt_r    <= b_r;
      out_depth_r  <= gd_r;
    end
  end

  assign out_free        = !out_valid_r || out_ready;
  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_bucket_used = BKT_OUT_W'(out_bkt_r);
  assign out_depth_now   = out_depth_r;

  // status towards the sequencer
  assign stat.in_valid   = in_valid;
  assign stat.rebuild    = cfg_wr && (reg_idx == REG_INIT_DEPTH);
  assign stat.sweep_done = done;
  assign stat.hit        = hit_r;
  assign stat.op         = op_r;
  assign stat.room       = (8'(used) < 8'(cap_r));
  assign stat.ld_ge      = (ld_r >= gd_r);
  assign stat.gd_max     = (gd_r >= DEPTH_W'(MAX_DEPTH));
  assign stat.alloc_full = (alloc_r >= (DIR_W + 1)'(DIR_SIZE));
  assign stat.out_free   = out_free;

endmodule

// File: design/extendible_hash_table.sv
// ----------------------------------------------------------------------------
// extendible_hash_table
// extendible hash set of keys with insert, search and delete
// ----------------------------------------------------------------------------
//  channel  | dir | handshake       | payload
//  in_ch    | in  | valid / ready   | op, key
//  out_ch   | out | valid / ready   | status, bucket_used, depth_now
//  apb      | in  | psel / penable  | paddr, pwdata, prdata (pready tied high)
//
//  search and delete time is set by the one-slot-a-cycle scan of the key memory;
//  an insert with room in the bucket adds a put step. each split sweeps the
//  directory to relink it and sweeps the bucket to move keys, and a doubling
//  first copies the lower half of the directory into the upper half.
//  after reset and after an initial_depth write while idle, a clearing pass
//  over all entries rebuilds the directory; in_ch.ready stays low throughout.
//  a new item is taken while the previous result waits in the output register.
// ----------------------------------------------------------------------------
module extendible_hash_table import eht_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  eht_in_if.sink             in_ch,
  eht_out_if.source          out_ch,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  eht_cmd_t  cmd;
  eht_stat_t stat;
  logic      ready;

  assign pready      = 1'b1;
  assign in_ch.ready = ready;

  eht_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .stat     (stat),
    .cmd      (cmd),
    .in_ready (ready)
  );

  eht_datapath u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .in_valid        (in_ch.valid),
    .in_accept       (in_ch.valid && ready),
    .in_op           (in_ch.op),
    .in_key          (in_ch.key),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .out_ready       (out_ch.ready),
    .out_valid       (out_ch.valid),
    .out_status      (out_ch.status),
    .out_bucket_used (out_ch.bucket_used),
    .out_depth_now   (out_ch.depth_now)
  );

endmodule

// File: design/eht_checker.sv
// ----------------------------------------------------------------------------
// eht_checker
// port-level checks on the hash table, bound to the top level
// ----------------------------------------------------------------------------
`include "extendible_hash_table_assert.svh"

module eht_checker import eht_pkg::*; (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic [STAT_W-1:0]    out_status,
  input logic [BKT_OUT_W-1:0] out_bucket_used,
  input logic [DEPTH_W-1:0]   out_depth_now
);

  // one item in flight at a time
  `EHT_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "ready after accept")

  // only defined status codes leave the block
  `EHT_ASSERT_IMPL(a_status_code, out_valid, out_status <= STAT_W'(ST_FULL), "bad status")

  // global depth stays within its range
  `EHT_ASSERT_IMPL(a_depth_range, out_valid, (out_depth_now != '0) && (out_depth_now <= DEPTH_W'(MAX_DEPTH)), "depth out of range")

  // stalled result stays put
  `EHT_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped")
  `EHT_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(out_status) && $stable(out_bucket_used) && $stable(out_depth_now), "result changed")

endmodule

bind extendible_hash_table eht_checker u_eht_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_status      (out_ch.status),
  .out_bucket_used (out_ch.bucket_used),
  .out_depth_now   (out_ch.depth_now)
);

// File: tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the extendible hash table: a shadow table in a small
// scoreboard class predicts status, bucket and depth of every item, while the
// channels idle and stall at random and the two registers are swept between
// phases, extremes and out-of-range values included
// ----------------------------------------------------------------------------
module tb_top;
  import eht_pkg::*;

  localparam logic [OP_W-1:0] OP_SPARE   = 2'd3;
  localparam int              KEY_POOL   = 64;
  localparam int              STALL_MAX  = 40000;
  localparam int              PHASE_ITEMS = 322;

  typedef struct {
    status_t              status;
    logic [BKT_OUT_W-1:0] bucket;
    logic [DEPTH_W-1:0]   depth;
  } hash_result_t;

  // shadow copy of the hash table and its expected results
  class hash_scoreboard;
    int unsigned          start_depth;
    int unsigned          capacity;
    int unsigned          gdepth;
    int unsigned          next_bucket;
    logic [7:0]           dir [DIR_SIZE];
    int unsigned          ldepth [DIR_SIZE];
    logic [KEY_BITS-1:0]  slot_key [KEY_DEPTH];
    bit                   slot_used [KEY_DEPTH];
    hash_result_t         pending [$];
    int                   errors;

    function new();
      start_depth = INIT_DEPTH_RST;
      capacity    = BKT_CAP_RST;
      errors      = 0;
      rebuild();
    endfunction

    function void rebuild();
      int unsigned n;
      n = 1 << start_depth;
      gdepth = start_depth;
      for (int i = 0; i < DIR_SIZE; i++) begin
        dir[i]    = 8'(i & (n - 1));
        ldepth[i] = (i < n) ? start_depth : 0;
      end
      foreach (slot_used[i]) slot_used[i] = 0;
      next_bucket = n;
    endfunction

    // register write, values saturate into range
    function void write_reg(logic idx, logic [PDATA_W-1:0] value);
      int unsigned v;
      v = value[3:0];
      if (v < 1) v = 1;
      if (idx == REG_INIT_DEPTH) begin
        if (v > MAX_DEPTH) v = MAX_DEPTH;
        start_depth = v;
        rebuild();
      end else begin
        if (v > BUCKET_SLOTS) v = BUCKET_SLOTS;
        capacity = v;
      end
    endfunction

    function int unsigned dir_of(logic [KEY_BITS-1:0] key);
      return key & ((1 << gdepth) - 1);
    endfunction

    function int find_key(int unsigned b, logic [KEY_BITS-1:0] key);
      for (int s = 0; s < BUCKET_SLOTS; s++)
        if (slot_used[b*BUCKET_SLOTS+s] && slot_key[b*BUCKET_SLOTS+s] == key) return s;
      return -1;
    endfunction

    function int free_of(int unsigned b);
      for (int s = 0; s < BUCKET_SLOTS; s++)
        if (!slot_used[b*BUCKET_SLOTS+s]) return s;
      return -1;
    endfunction

    function int unsigned fill_of(int unsigned b);
      int unsigned c;
      c = 0;
      for (int s = 0; s < BUCKET_SLOTS; s++) c += slot_used[b*BUCKET_SLOTS+s];
      return c;
    endfunction

    // split bucket b on its next bit, moving keys with that bit set
    function bit split(int unsigned b);
      int unsigned nb, mask, n;
      int t;
      if (next_bucket >= DIR_SIZE) return 0;
      nb = next_bucket++;
      ldepth[b]++;
      ldepth[nb] = ldepth[b];
      mask = 1 << (ldepth[b] - 1);
      n = 1 << gdepth;
      for (int i = 0; i < n && i < DIR_SIZE; i++)
        if (dir[i] == b && (i & mask)) dir[i] = 8'(nb);
      for (int s = 0; s < BUCKET_SLOTS; s++) slot_used[nb*BUCKET_SLOTS+s] = 0;
      for (int s = 0; s < BUCKET_SLOTS; s++) begin
        if (slot_used[b*BUCKET_SLOTS+s] && (slot_key[b*BUCKET_SLOTS+s] & mask)) begin
          t = free_of(nb);
          if (t >= 0) begin
            slot_key[nb*BUCKET_SLOTS+t]  = slot_key[b*BUCKET_SLOTS+s];
            slot_used[nb*BUCKET_SLOTS+t] = 1;
            slot_used[b*BUCKET_SLOTS+s]  = 0;
          end
        end
      end
      return 1;
    endfunction

    // accepted input item: update the shadow table, queue the expected result
    function void note_item(logic [OP_W-1:0] op, logic [KEY_BITS-1:0] key);
      int unsigned b, n;
      int s, t;
      status_t st;
      hash_result_t r;
      b = dir[dir_of(key)];
      s = find_key(b, key);
      if (op == OP_INSERT) begin
        if (s >= 0) st = ST_PRESENT;
        else begin
          st = ST_INSERTED;
          forever begin
            b = dir[dir_of(key)];
            if (fill_of(b) < capacity) begin
              t = free_of(b);
              if (t < 0) begin
                st = ST_FULL;
                break;
              end
              slot_key[b*BUCKET_SLOTS+t]  = key;
              slot_used[b*BUCKET_SLOTS+t] = 1;
              break;
            end
            if (ldepth[b] >= gdepth) begin
              if (gdepth >= MAX_DEPTH) begin
                st = ST_FULL;
                break;
              end
              n = 1 << gdepth;
              for (int i = 0; i < n; i++) dir[i+n] = dir[i];
              gdepth++;
            end
            if (!split(b)) begin
              st = ST_FULL;
              break;
            end
          end
        end
      end else if (op == OP_DELETE) begin
        if (s >= 0) begin
          slot_used[b*BUCKET_SLOTS+s] = 0;
          st = ST_DELETED;
        end else st = ST_NOTFOUND;
      end else begin
        st = (s >= 0) ? ST_FOUND : ST_NOTFOUND;
      end
      r.status = st;
      r.bucket = b[7:0];
      r.depth  = gdepth[3:0];
      pending = {pending, r};
    endfunction

    task report(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      errors++;
    endtask

    // accepted result: compare with the oldest expectation
    task check_result(logic [STAT_W-1:0] st, logic [BKT_OUT_W-1:0] bkt,
                      logic [DEPTH_W-1:0] dep);
      hash_result_t r;
      if (pending.size() == 0) begin
        report("result with nothing expected");
        return;
      end
      r = pending.pop_front();
      if (st !== r.status)
        report($sformatf("status %0d, expected %0d", st, r.status));
      if (bkt !== r.bucket)
        report($sformatf("bucket %0d, expected %0d", bkt, r.bucket));
      if (dep !== r.depth)
        report($sformatf("depth %0d, expected %0d", dep, r.depth));
    endtask
  endclass

  logic clk;
  logic rst_n;
  logic psel, penable, pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic pready;

  eht_in_if  in_ch ();
  eht_out_if out_ch ();

  extendible_hash_table dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  hash_scoreboard sb = new();
  int unsigned         send_idle;
  int unsigned         recv_stall;
  int unsigned         quiet_cycles = 0;
  logic [KEY_BITS-1:0] pool [KEY_POOL];

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // monitors: accepted items feed the scoreboard
  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready) sb.note_item(in_ch.op, in_ch.key);
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_result(out_ch.status, out_ch.bucket_used, out_ch.depth_now);
  end

  // receiver back-pressure
  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(0, 99) >= recv_stall);
  end

  // watchdog on cycles with no progress on any port
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || psel)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > STALL_MAX) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // one item on the request channel, valid held high after acceptance
  task send_item(logic [OP_W-1:0] op, logic [KEY_BITS-1:0] key);
    if ($urandom_range(0, 99) < send_idle) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(0, 99) < send_idle) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.op    <= op;
    in_ch.key   <= key;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // drain results and let the block settle before touching registers
  task drain;
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task write_reg(logic idx, logic [PDATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    sb.write_reg(idx, value);
    @(posedge clk);
  endtask

  // pool keys share few low bits so buckets fill and split
  function logic [KEY_BITS-1:0] pick_key();
    if ($urandom_range(0, 9) < 8) return pool[$urandom_range(0, KEY_POOL - 1)];
    return $urandom;
  endfunction

  task random_items(int unsigned count);
    int unsigned roll;
    logic [OP_W-1:0] op;
    for (int i = 0; i < count; i++) begin
      roll = $urandom_range(0, 99);
      if (roll < 50) op = OP_INSERT;
      else if (roll < 78) op = OP_SEARCH;
      else if (roll < 95) op = OP_DELETE;
      else op = OP_SPARE;
      send_item(op, pick_key());
    end
  endtask

  initial begin
    int unsigned depth_set [6] = '{1, 0, 15, 8, 3, 1};
    int unsigned cap_set   [6] = '{4, 15, 0, 1, 2, 8};
    int unsigned idle_set  [6] = '{0, 60, 0, 36, 0, 60};
    int unsigned stall_set [6] = '{0, 0, 60, 36, 0, 60};
    rst_n        = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.op     = OP_INSERT;
    in_ch.key    = '0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    send_idle    = 0;
    recv_stall   = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: corner keys, every op, duplicate, miss, spare op, overflow to full
    send_item(OP_INSERT, 32'h0);
    send_item(OP_INSERT, 32'h0);
    send_item(OP_SEARCH, 32'h0);
    send_item(OP_SEARCH, 32'hFFFF_FFFF);
    send_item(OP_INSERT, 32'hFFFF_FFFF);
    send_item(OP_SPARE,  32'hFFFF_FFFF);
    send_item(OP_DELETE, 32'hFFFF_FFFF);
    send_item(OP_DELETE, 32'hFFFF_FFFF);
    send_item(OP_SPARE,  32'h1234_5678);
    for (int i = 1; i <= 7; i++) send_item(OP_INSERT, i << 8);
    send_item(OP_SEARCH, 32'h0000_0300);
    send_item(OP_DELETE, 32'h0000_0300);
    send_item(OP_INSERT, 32'h8000_0000);
    send_item(OP_SEARCH, 32'h0000_0700);
    drain();

    // random phases across register settings and idling levels
    for (int p = 0; p < 6; p++) begin
      write_reg(REG_INIT_DEPTH, depth_set[p]);
      write_reg(REG_BKT_CAP, cap_set[p]);
      foreach (pool[i]) pool[i] = ($urandom & 32'hFFFF_FF00) | $urandom_range(0, 63);
      send_idle  = 0;
      recv_stall = 0;
      random_items(60);
      send_idle  = idle_set[p];
      recv_stall = stall_set[p];
      random_items(PHASE_ITEMS - 60);
      drain();
    end

    if (sb.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+design
design/eht_pkg.sv
design/eht_in_if.sv
design/eht_out_if.sv
design/eht_ram.sv
design/eht_ctrl.sv
design/eht_datapath.sv
design/extendible_hash_table.sv
design/eht_checker.sv
tb/tb_top.sv
